@@ rtl/mmps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmps_pkg
// Shared types and constants of the motor mode and PWM duty scaler.
// ----------------------------------------------------------------------------
package mmps_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned SPD_W  = 8;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned CAL_W  = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // floor(x / 25) == (x * RECIP_25) >> 26 for x < 2^21
  localparam int unsigned RECIP_W  = 22;
  localparam int unsigned K_W      = CAL_W + RECIP_W;
  localparam int unsigned PROD_W   = PCT_W + K_W;
  localparam int unsigned Q_LSB    = 20;
  localparam logic [RECIP_W-1:0] RECIP_25 = 22'd2684355;

  localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
  localparam logic [SPD_W-1:0] TRY_LO   = 8'd50;
  localparam logic [SPD_W-1:0] TRY_HI   = 8'd70;
  localparam logic [SPD_W-1:0] TRY_ADD1 = 8'd20;
  localparam logic [SPD_W-1:0] TRY_ADD2 = 8'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_MAX = 2'd3;

  localparam logic [CAL_W-1:0] CAL_MIN_RST = 8'd0;
  localparam logic [CAL_W-1:0] CAL_MAX_RST = 8'd100;

  typedef enum logic [OP_W-1:0] {
    OP_PROCESS  = 4'd0,
    OP_START    = 4'd1,
    OP_STOP     = 4'd2,
    OP_ERROR    = 4'd3,
    OP_TRY      = 4'd4,
    OP_NORMAL   = 4'd5,
    OP_REGULATE = 4'd6,
    OP_INIT     = 4'd7,
    OP_DEINIT   = 4'd8
  } op_e;

  typedef enum logic [6:0] {
    MODE_UNINIT = 7'b0000001,
    MODE_OFF    = 7'b0000010,
    MODE_ACCEL  = 7'b0000100,
    MODE_ON     = 7'b0001000,
    MODE_TRY    = 7'b0010000,
    MODE_ERROR  = 7'b0100000,
    MODE_REG    = 7'b1000000
  } mode_e;

  localparam logic [MODE_W-1:0] MODE_CODE_UNINIT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_OFF    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_ACCEL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_ON     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_TRY    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_ERROR  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_REG    = 3'd6;

  function automatic logic [MODE_W-1:0] mode_code(input mode_e m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_OFF:   c = MODE_CODE_OFF;
      MODE_ACCEL: c = MODE_CODE_ACCEL;
      MODE_ON:    c = MODE_CODE_ON;
      MODE_TRY:   c = MODE_CODE_TRY;
      MODE_ERROR: c = MODE_CODE_ERROR;
      MODE_REG:   c = MODE_CODE_REG;
      default:    c = MODE_CODE_UNINIT;
    endcase
    return c;
  endfunction

  function automatic logic is_running(input mode_e m);
    return (m == MODE_ACCEL) || (m == MODE_ON) || (m == MODE_TRY);
  endfunction

endpackage

@@ rtl/mmps_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmps_in_if / mmps_out_if
// Valid/ready channels for commands and results of the motor mode scaler.
// ----------------------------------------------------------------------------
interface mmps_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [7:0]  speed_value;
  logic [15:0] regulation_duty;

  modport source(output valid, output opcode, output speed_value,
                 output regulation_duty, input ready);
  modport sink(input valid, input opcode, input speed_value,
               input regulation_duty, output ready);
endinterface

interface mmps_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty;
  logic        accepted;
  logic [2:0]  mode;
  logic        motor_running;

  modport source(output valid, output duty, output accepted, output mode,
                 output motor_running, input ready);
  modport sink(input valid, input duty, input accepted, input mode,
               input motor_running, output ready);
endinterface

@@ rtl/motor_mode_pwm_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_mode_pwm_scaler
// Motor mode machine with calibrated Q8.8 duty scaling.
// ----------------------------------------------------------------------------
// Takes one command transaction per clock while the result side does not
// stall, and returns one result per command. A command is held in an input
// register, then one pass of logic updates the mode and duty registers and
// loads the result register in the same edge; a stalled result holds both
// stages. Scaling uses one 7 x 30 bit product against a registered window
// factor from the configuration registers. The user must ensure configuration
// is written only while no command is in flight; the block does not check it.
module motor_mode_pwm_scaler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mmps_in_if.sink                     in_if,
  mmps_out_if.source                  out_if,
  input  logic                        cfg_we_i,
  input  logic [mmps_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mmps_pkg::CAL_W-1:0]  cfg_data_i
);
  import mmps_pkg::*;

  // configuration
  logic [CAL_W-1:0] cal_min_q, cal_max_q, def_min_q, def_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_min_q <= CAL_MIN_RST;
      cal_max_q <= CAL_MAX_RST;
      def_min_q <= CAL_MIN_RST;
      def_max_q <= CAL_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAL_MIN: cal_min_q <= cfg_data_i;
        CFG_CAL_MAX: cal_max_q <= cfg_data_i;
        CFG_DEF_MIN: def_min_q <= cfg_data_i;
        CFG_DEF_MAX: def_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window factor: |max - min| * RECIP_25
  logic [CAL_W-1:0] lo_d, hi_d, span_d;
  logic             neg_d;
  logic [K_W-1:0]   k_d;
  logic [CAL_W-1:0] lo_q;
  logic             neg_q;
  logic [K_W-1:0]   k_q;

  always_comb begin
    if (cal_min_q > cal_max_q) begin
      lo_d = def_min_q;
      hi_d = def_max_q;
    end else begin
      lo_d = cal_min_q;
      hi_d = cal_max_q;
    end
    neg_d  = lo_d > hi_d;
    span_d = neg_d ? (lo_d - hi_d) : (hi_d - lo_d);
    k_d    = K_W'(span_d) * K_W'(RECIP_25);
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    neg_q <= neg_d;
    k_q   <= k_d;
  end

  // handshake
  logic in_vld_q, out_vld_q, adv, fire;
  logic [OP_W-1:0]   op_q;
  logic [SPD_W-1:0]  spd_q;
  logic [DUTY_W-1:0] reg_q;

  assign adv         = !out_vld_q || out_if.ready;
  assign fire        = in_vld_q && adv;
  assign in_if.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      op_q  <= in_if.opcode;
      spd_q <= in_if.speed_value;
      reg_q <= in_if.regulation_duty;
    end
  end

  // duty scaling
  mode_e             mode_q, mode_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              acc;
  logic [SPD_W-1:0]  spd_adj;
  logic [PCT_W-1:0]  pct;
  logic [PROD_W-1:0] prod;
  logic [DUTY_W-1:0] qmag, qoff, scaled;

  always_comb begin
    spd_adj = spd_q;
    if (mode_q == MODE_TRY) begin
      if (spd_q <= TRY_LO) begin
        spd_adj = spd_q + TRY_ADD1;
      end else if (spd_q <= TRY_HI) begin
        spd_adj = spd_q + TRY_ADD2;
      end
    end
    pct    = (spd_adj > SPD_W'(PCT_MAX)) ? PCT_MAX : spd_adj[PCT_W-1:0];
    prod   = PROD_W'(pct) * PROD_W'(k_q);
    qmag   = prod[Q_LSB +: DUTY_W];
    qoff   = neg_q ? (~qmag + DUTY_W'(1)) : qmag;
    scaled = (pct == '0) ? '0 : ({lo_q, 8'h00} + qoff);
  end

  // mode machine
  always_comb begin
    mode_d = mode_q;
    duty_d = duty_q;
    acc    = 1'b0;
    case (op_q)
      OP_PROCESS: begin
        acc = 1'b1;
        case (mode_q)
          MODE_ON, MODE_REG, MODE_TRY: duty_d = scaled;
          MODE_OFF:   duty_d = '0;
          MODE_ACCEL: mode_d = MODE_ON;
          default:    acc = 1'b0;
        endcase
      end
      OP_START: begin
        if (mode_q == MODE_OFF) begin
          mode_d = MODE_ACCEL;
          acc    = 1'b1;
        end
      end
      OP_STOP: begin
        if (is_running(mode_q)) begin
          mode_d = MODE_OFF;
          acc    = 1'b1;
        end
      end
      OP_ERROR: begin
        mode_d = MODE_ERROR;
        acc    = 1'b1;
      end
      OP_TRY: begin
        if (is_running(mode_q)) begin
          mode_d = MODE_TRY;
          acc    = 1'b1;
        end
      end
      OP_NORMAL: begin
        if (is_running(mode_q)) begin
          mode_d = MODE_ON;
          acc    = 1'b1;
        end
      end
      OP_REGULATE: begin
        mode_d = MODE_REG;
        duty_d = reg_q;
        acc    = 1'b1;
      end
      OP_INIT: begin
        mode_d = MODE_OFF;
        acc    = 1'b1;
      end
      OP_DEINIT: begin
        mode_d = MODE_UNINIT;
        acc    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_UNINIT;
      duty_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d;
      duty_q <= duty_d;
    end
  end

  // result register
  logic [DUTY_W-1:0] out_duty_q;
  logic              out_acc_q, out_run_q;
  logic [MODE_W-1:0] out_mode_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_duty_q <= duty_d;
      out_acc_q  <= acc;
      out_mode_q <= mode_code(mode_d);
      out_run_q  <= is_running(mode_d);
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.duty          = out_duty_q;
  assign out_if.accepted      = out_acc_q;
  assign out_if.mode          = out_mode_q;
  assign out_if.motor_running = out_run_q;

endmodule

@@ rtl/mmps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmps_checker
// Port-level assertions for motor_mode_pwm_scaler, attached by bind.
// ----------------------------------------------------------------------------
module mmps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_duty_i,
  input logic [2:0]  out_mode_i,
  input logic        out_running_i
);
  import mmps_pkg::*;

  // running flag agrees with the reported mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_running_i == ((out_mode_i == MODE_CODE_ACCEL) ||
                                       (out_mode_i == MODE_CODE_ON) ||
                                       (out_mode_i == MODE_CODE_TRY))))
    else $error("motor_running does not match mode");

  // a transaction reaches the result register once the result side takes data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) ##1 out_ready_i |=> out_valid_i)
    else $error("accepted command produced no result");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_duty_i) &&
                                       $stable(out_mode_i)))
    else $error("stalled result changed");

  // input side never stalls while the result register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !$past(in_valid_i && in_ready_i)) |-> in_ready_i)
    else $error("input stalled with empty pipeline");

endmodule

bind motor_mode_pwm_scaler mmps_checker u_mmps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_duty_i    (out_if.duty),
  .out_mode_i    (out_if.mode),
  .out_running_i (out_if.motor_running)
);
